/* sv/ppm_pkg.sv */
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared constants, register indexes and controller/datapath interface types
// for the PPM frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ppm_pkg;

   // frame geometry and lock rules
   localparam int CHANNELS      = 8;
   localparam int STABLE_FRAMES = 25;
   localparam int MIN_LOCK      = 4;
   localparam int MAX_LOCK      = 16;
   localparam int EARLY_CAPTURE = 32;

   localparam int IDX_W  = $clog2(CHANNELS);
   localparam int PC_W   = $clog2(CHANNELS + 1);
   localparam int LOCK_W = $clog2(MAX_LOCK + 1);
   localparam int ST_W   = $clog2(STABLE_FRAMES + 1);

   localparam int TIME_W = 32;
   localparam int CNT_W  = 16;
   localparam int CSR_W  = 16;
   localparam int CHN_W  = 3;

   localparam logic [CNT_W-1:0] NO_SIGNAL = '1;

   // configuration register indexes
   typedef enum logic [1:0] {
      REG_RELOAD    = 2'd0,
      REG_SYNC_MIN  = 2'd1,
      REG_PULSE_MIN = 2'd2,
      REG_PULSE_MAX = 2'd3
   } reg_index_type;

   localparam logic [CSR_W-1:0] RELOAD_RESET    = 16'd65535;
   localparam logic [CSR_W-1:0] SYNC_MIN_RESET  = 16'd2700;
   localparam logic [CSR_W-1:0] PULSE_MIN_RESET = 16'd750;
   localparam logic [CSR_W-1:0] PULSE_MAX_RESET = 16'd2250;

   // controller to datapath
   typedef struct packed {
      logic load_in;
      logic pre_add;
      logic calc_now;
      logic calc_gap;
      logic decide;
      logic emit_load;
   } dec_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic edge_seen;
      logic is_sync;
      logic slot_free;
      logic emit_last;
   } dec_status_type;

endpackage

`default_nettype wire

/* sv/ppm_datapath.sv */
// ----------------------------------------------------------------------------
// ppm_datapath
// Extended time base, gap measurement, channel buffer, lock tracking and the
// output register for channel words.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_datapath
   import ppm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dec_cmd_type        cmd,
   output dec_status_type          status,
   input  wire logic               req_edge_seen,
   input  wire logic               req_overflow_seen,
   input  wire logic [CNT_W-1:0]   req_capture_count,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [CSR_W-1:0]   csr_wdata,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [CHN_W-1:0]        rsp_channel_number,
   output logic [CNT_W-1:0]        rsp_channel_width,
   output logic                    rsp_frame_accepted,
   output logic                    rsp_last
);

   // configuration registers
   logic [CSR_W-1:0] reload_ff, sync_min_ff, pulse_min_ff, pulse_max_ff;

   // latched request
   logic             edge_ff, ovf_ff;
   logic [CNT_W-1:0] cap_ff;

   // time base
   logic [TIME_W-1:0] ext_ff, ext_in;
   logic [TIME_W-1:0] prev_ff, now_ff, gap_ff;

   // frame state
   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [PC_W-1:0]  locked_ff, locked_in;
   logic [PC_W-1:0]  prev_count_ff;
   logic             prev_valid_ff;
   logic [ST_W-1:0]  stable_ff, stable_in;
   logic             tracking_ff, tracking_in;
   logic             accepted_ff;
   logic [CNT_W-1:0] frame_buf [CHANNELS];

   // emission
   logic [IDX_W-1:0] emit_idx_ff;
   logic             rsp_valid_ff;
   logic [CHN_W-1:0] rsp_chn_ff;
   logic [CNT_W-1:0] rsp_width_ff;
   logic             rsp_acc_ff, rsp_last_ff;

   logic early_cap, is_sync, in_window, lock_match, buf_write, emit_last;
   logic [CNT_W-1:0] emit_width;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff    <= RELOAD_RESET;
         sync_min_ff  <= SYNC_MIN_RESET;
         pulse_min_ff <= PULSE_MIN_RESET;
         pulse_max_ff <= PULSE_MAX_RESET;
      end else if (csr_write) begin
         unique case (reg_index_type'(csr_index))
            REG_RELOAD:    reload_ff    <= csr_wdata;
            REG_SYNC_MIN:  sync_min_ff  <= csr_wdata;
            REG_PULSE_MIN: pulse_min_ff <= csr_wdata;
            REG_PULSE_MAX: pulse_max_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // an edge with a small capture came after the overflow
   assign early_cap = cap_ff < CNT_W'(EARLY_CAPTURE);

   // gap classification
   assign is_sync   = gap_ff > {{(TIME_W-CSR_W){1'b0}}, sync_min_ff};
   assign in_window = (gap_ff > {{(TIME_W-CSR_W){1'b0}}, pulse_min_ff}) &&
                      (gap_ff < {{(TIME_W-CSR_W){1'b0}}, pulse_max_ff}) &&
                      (pc_ff < PC_W'(CHANNELS));
   assign buf_write = cmd.decide && !is_sync && tracking_ff && in_window;

   // lock bookkeeping at frame end
   assign lock_match = prev_valid_ff && (pc_ff == prev_count_ff) &&
                       (LOCK_W'(pc_ff) >= LOCK_W'(MIN_LOCK)) &&
                       (LOCK_W'(pc_ff) <= LOCK_W'(MAX_LOCK));

   always_comb begin
      stable_in = stable_ff;
      locked_in = locked_ff;
      if (lock_match) begin
         if (stable_ff < ST_W'(STABLE_FRAMES)) stable_in = stable_ff + 1'b1;
         else                                  locked_in = pc_ff;
      end else begin
         stable_in = '0;
      end
   end

   // time base next value
   always_comb begin
      ext_in = ext_ff;
      if (cmd.pre_add && ovf_ff && (!edge_ff || early_cap))
         ext_in = ext_ff + {{(TIME_W-CSR_W){1'b0}}, reload_ff};
      else if (cmd.calc_gap && ovf_ff && !early_cap)
         ext_in = ext_ff + {{(TIME_W-CSR_W){1'b0}}, reload_ff};
   end

   // pulse count and tracking next value
   always_comb begin
      pc_in       = pc_ff;
      tracking_in = tracking_ff;
      if (cmd.decide) begin
         if (is_sync) begin
            pc_in       = '0;
            tracking_in = 1'b1;
         end else if (tracking_ff) begin
            if (in_window) pc_in       = pc_ff + 1'b1;
            else           tracking_in = 1'b0;
         end
      end
   end

   // request latch and time stamps
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         edge_ff <= req_edge_seen;
         ovf_ff  <= req_overflow_seen;
         cap_ff  <= req_capture_count;
      end
      if (cmd.calc_now) now_ff <= ext_ff + {{(TIME_W-CNT_W){1'b0}}, cap_ff};
      if (cmd.calc_gap) gap_ff <= now_ff - prev_ff;
      if (buf_write) frame_buf[pc_ff[IDX_W-1:0]] <= gap_ff[CNT_W-1:0];
   end

   // frame and time state
   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff        <= '0;
         prev_ff       <= '0;
         pc_ff         <= '0;
         locked_ff     <= '0;
         prev_count_ff <= '0;
         prev_valid_ff <= 1'b0;
         stable_ff     <= '0;
         tracking_ff   <= 1'b1;
         accepted_ff   <= 1'b0;
      end else begin
         ext_ff      <= ext_in;
         pc_ff       <= pc_in;
         tracking_ff <= tracking_in;
         if (cmd.calc_gap) prev_ff <= now_ff;
         if (cmd.decide && is_sync) begin
            stable_ff     <= stable_in;
            locked_ff     <= locked_in;
            accepted_ff   <= (pc_ff == locked_in) && tracking_ff;
            prev_count_ff <= pc_ff;
            prev_valid_ff <= 1'b1;
         end
      end
   end

   // channel word for the current emit index
   assign emit_last  = emit_idx_ff == IDX_W'(CHANNELS - 1);
   assign emit_width = (accepted_ff && (PC_W'(emit_idx_ff) < locked_ff)) ?
                       frame_buf[emit_idx_ff] : NO_SIGNAL;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         emit_idx_ff  <= '0;
      end else begin
         if (cmd.decide && is_sync) emit_idx_ff <= '0;
         else if (cmd.emit_load)    emit_idx_ff <= emit_idx_ff + 1'b1;
         if (cmd.emit_load)         rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)       rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_chn_ff   <= CHN_W'(emit_idx_ff);
         rsp_width_ff <= emit_width;
         rsp_acc_ff   <= accepted_ff;
         rsp_last_ff  <= emit_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_channel_number = rsp_chn_ff;
   assign rsp_channel_width  = rsp_width_ff;
   assign rsp_frame_accepted = rsp_acc_ff;
   assign rsp_last           = rsp_last_ff;

   assign status.edge_seen = edge_ff;
   assign status.is_sync   = is_sync;
   assign status.slot_free = !rsp_valid_ff || !rsp_stall;
   assign status.emit_last = emit_last;

   // checks
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= PC_W'(CHANNELS))
      else $error("pulse count beyond buffer depth");

   a_locked_range: assert property (@(posedge clock) disable iff (reset)
      (locked_ff == '0) ||
      ((LOCK_W'(locked_ff) >= LOCK_W'(MIN_LOCK)) && (locked_ff <= PC_W'(CHANNELS))))
      else $error("locked channel count out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("channel word overwritten while stalled");

   a_reject_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_acc_ff) |-> (rsp_width_ff == NO_SIGNAL))
      else $error("rejected frame carries a width");

endmodule

`default_nettype wire

/* sv/ppm_ctrl.sv */
// ----------------------------------------------------------------------------
// ppm_ctrl
// Sequencer for one timer event: overflow pre-add, time stamp, gap, decision,
// and at a sync gap the emission of all channel words.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_ctrl
   import ppm_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire dec_status_type status,
   output dec_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRE,
      ST_NOW,
      ST_GAP,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   state_type state_ff;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE:   if (req_valid) state_ff <= ST_PRE;
            ST_PRE:    state_ff <= status.edge_seen ? ST_NOW : ST_IDLE;
            ST_NOW:    state_ff <= ST_GAP;
            ST_GAP:    state_ff <= ST_DECIDE;
            ST_DECIDE: state_ff <= status.is_sync ? ST_EMIT : ST_IDLE;
            ST_EMIT:   if (status.slot_free && status.emit_last) state_ff <= ST_IDLE;
            default:   state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = state_ff != ST_IDLE;

   // commands
   always_comb begin
      cmd           = '0;
      cmd.load_in   = (state_ff == ST_IDLE) && req_valid;
      cmd.pre_add   = state_ff == ST_PRE;
      cmd.calc_now  = state_ff == ST_NOW;
      cmd.calc_gap  = state_ff == ST_GAP;
      cmd.decide    = state_ff == ST_DECIDE;
      cmd.emit_load = (state_ff == ST_EMIT) && status.slot_free;
   end

   // checks
   a_emit_after_sync: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && $past(state_ff == ST_DECIDE)) |->
      $past(status.is_sync))
      else $error("emission entered without sync gap");

   a_single_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_in |=> !cmd.load_in)
      else $error("second request taken while busy");

   a_decide_order: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |-> $past(cmd.calc_gap))
      else $error("decision without fresh gap");

endmodule

`default_nettype wire

/* sv/ppm_frame_decoder.sv */
// ----------------------------------------------------------------------------
// ppm_frame_decoder
// Decoder for pulse position modulation frames from timer capture events.
//
// Usage:
//   Request channel (req_): one timer event per request: edge flag, overflow
//   flag and 16-bit capture count. A request is taken when req_valid is high
//   and req_stall is low; req_stall is high while an event is being worked.
//   Response channel (rsp_): at a sync gap the block sends eight channel
//   words, number 0 to 7, last set on word 7, 65535 meaning no signal.
//   Sequence: an overflow-only event passes only the pre-add step; an edge
//   event walks the pre-add, time stamp, gap and decision steps in order on
//   the 32-bit time base. A sync edge then emits one channel word per cycle
//   through the single output register while the receiver does not stall.
//   Stall: a stalled response word holds in the output register; emission
//   and request intake wait until it is taken. The next request may be
//   taken while the final word still waits.
//   Reset: synchronous; clears time base, lock state and pending output, and
//   loads the default register values. Registers are to be written through
//   csr_ only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_frame_decoder
   import ppm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_edge_seen,
   input  wire logic              req_overflow_seen,
   input  wire logic [CNT_W-1:0]  req_capture_count,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [CHN_W-1:0]       rsp_channel_number,
   output logic [CNT_W-1:0]       rsp_channel_width,
   output logic                   rsp_frame_accepted,
   output logic                   rsp_last,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_index,
   input  wire logic [CSR_W-1:0]  csr_wdata
);

   dec_cmd_type    cmd;
   dec_status_type status;

   // sequencer
   ppm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   ppm_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_edge_seen      (req_edge_seen),
      .req_overflow_seen  (req_overflow_seen),
      .req_capture_count  (req_capture_count),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_channel_number (rsp_channel_number),
      .rsp_channel_width  (rsp_channel_width),
      .rsp_frame_accepted (rsp_frame_accepted),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire
